/* rtl/core/gpi_pkg.sv */
// ----------------------------------------------------------------------------
// gpi_pkg: shared types and constants
// Item, configuration and mode types for the grid potential interpolator.
// ----------------------------------------------------------------------------
package gpi_pkg;

	localparam int MAX_ROWS    = 128;
	localparam int MAX_COLS    = 128;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int NUM_BANKS   = 4;
	localparam int BANK_AW     = ROW_W - 1 + COL_W - 1;
	localparam int BANK_DEPTH  = (MAX_ROWS * MAX_COLS) / NUM_BANKS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int PADDR_W     = 5;

	localparam logic [2:0] REG_INV_SPACING    = 3'd0;
	localparam logic [2:0] REG_POTENTIAL_GAIN = 3'd1;
	localparam logic [2:0] REG_FIELD_GAIN     = 3'd2;
	localparam logic [2:0] REG_ROWS_USED      = 3'd3;
	localparam logic [2:0] REG_COLS_USED      = 3'd4;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_POT   = 2'd1,
		MODE_FIELD = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [16:0]        value;
		logic [30:0]        radius;
		logic signed [31:0] axial;
	} item_t;

	typedef struct packed {
		logic [31:0] inv_spacing;
		logic [31:0] potential_gain;
		logic [31:0] field_gain;
		logic [7:0]  rows_used;
		logic [7:0]  cols_used;
	} cfg_t;

endpackage

/* rtl/core/gpi_if.sv */
// ----------------------------------------------------------------------------
// gpi_if: channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gpi_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [6:0]         row;
	logic [6:0]         col;
	logic [16:0]        value;
	logic [30:0]        radius;
	logic signed [31:0] axial;

	modport source(output valid, mode, row, col, value, radius, axial, input ready);
	modport sink(input valid, mode, row, col, value, radius, axial, output ready);
endinterface

interface gpi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] potential;
	logic signed [31:0] field_radial;
	logic signed [31:0] field_axial;

	modport source(output valid, potential, field_radial, field_axial, input ready);
	modport sink(input valid, potential, field_radial, field_axial, output ready);
endinterface

/* rtl/core/gpi_cfg.sv */
// ----------------------------------------------------------------------------
// gpi_cfg: configuration registers
// APB-style register file holding spacing, gains and lattice extent.
// ----------------------------------------------------------------------------
module gpi_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output gpi_pkg::cfg_t               cfg
);

	gpi_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx   = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_spacing    <= 32'd65536;
			cfg_q.potential_gain <= 32'd65536;
			cfg_q.field_gain     <= 32'd65536;
			cfg_q.rows_used      <= 8'd128;
			cfg_q.cols_used      <= 8'd128;
		end else if (wr_en) begin
			case (idx)
				gpi_pkg::REG_INV_SPACING:    cfg_q.inv_spacing    <= pwdata;
				gpi_pkg::REG_POTENTIAL_GAIN: cfg_q.potential_gain <= pwdata;
				gpi_pkg::REG_FIELD_GAIN:     cfg_q.field_gain     <= pwdata;
				gpi_pkg::REG_ROWS_USED:      cfg_q.rows_used      <= pwdata[7:0];
				gpi_pkg::REG_COLS_USED:      cfg_q.cols_used      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gpi_pkg::REG_INV_SPACING:    prdata = cfg_q.inv_spacing;
			gpi_pkg::REG_POTENTIAL_GAIN: prdata = cfg_q.potential_gain;
			gpi_pkg::REG_FIELD_GAIN:     prdata = cfg_q.field_gain;
			gpi_pkg::REG_ROWS_USED:      prdata = {24'd0, cfg_q.rows_used};
			gpi_pkg::REG_COLS_USED:      prdata = {24'd0, cfg_q.cols_used};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/core/gpi_front.sv */
// ----------------------------------------------------------------------------
// gpi_front: item intake and queue
// Accepts items, drops unused modes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module gpi_front (
	input  logic            clk,
	input  logic            arst_n,
	gpi_item_if.sink        item,
	output logic            head_valid,
	output gpi_pkg::item_t  head,
	input  logic            pop
);

	gpi_pkg::item_t              q_mem [gpi_pkg::QUEUE_DEPTH];
	logic [gpi_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gpi_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gpi_pkg::QPTR_W:0]    count_q;
	gpi_pkg::item_t              in_item;
	logic                        push;
	logic                        do_pop;

	assign item.ready = (count_q != (gpi_pkg::QPTR_W+1)'(gpi_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];

	always_comb begin
		in_item.mode   = gpi_pkg::mode_t'(item.mode);
		in_item.row    = item.row;
		in_item.col    = item.col;
		in_item.value  = item.value;
		in_item.radius = item.radius;
		in_item.axial  = item.axial;
	end

	assign push   = item.valid && item.ready && (in_item.mode != gpi_pkg::MODE_NONE);
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/gpi_back.sv */
// ----------------------------------------------------------------------------
// gpi_back: table and interpolation pipeline
// Banked potential table, vertex fetch, bilinear weighting and scaling.
// ----------------------------------------------------------------------------
module gpi_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gpi_pkg::cfg_t   cfg,
	input  logic            head_valid,
	input  gpi_pkg::item_t  head,
	output logic            pop,
	gpi_result_if.source    result
);

	localparam int RW = gpi_pkg::ROW_W;
	localparam int CW = gpi_pkg::COL_W;
	localparam int AW = gpi_pkg::BANK_AW;
	localparam int NB = gpi_pkg::NUM_BANKS;

	function automatic logic [31:0] neg_sat(input logic [35:0] q, input logic pos);
		logic [31:0] r;
		if (pos) begin
			r = (q > 36'h080000000) ? 32'h80000000 : q[31:0];
			r = 32'd0 - r;
		end else begin
			r = (q > 36'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		end
		return r;
	endfunction

	logic adv;
	logic res_valid_q;

	// stage 1: position products
	logic                v_s1;
	gpi_pkg::mode_t      mode_s1;
	logic [RW-1:0]       row_s1;
	logic [CW-1:0]       col_s1;
	logic [16:0]         val_s1;
	logic                neg_s1;
	logic [63:0]         max_s1;
	logic [63:0]         mrad_s1;
	logic [31:0]         ax_bits;
	logic [31:0]         ax_mag;

	// stage 1 decode
	logic                neg_eff;
	logic [63:0]         qm;
	logic [23:0]         base_i;
	logic [24:0]         ri0, ri1, cj0, cj1;
	logic [15:0]         fa, fb;
	logic [7:0]          rmax, cmax;
	logic [AW-1:0]       raddr [NB];
	logic [NB-1:0]       we;
	logic [AW-1:0]       waddr;

	// stage 2: table data
	logic                v_s2, fld_s2;
	logic                r0p_s2, c0p_s2;
	logic                okr0_s2, okr1_s2, okc0_s2, okc1_s2;
	logic [15:0]         a_s2, b_s2;
	logic [16:0]         rd_s2 [NB];
	logic [16:0]         p00, p01, p10, p11;
	logic [16:0]         wa0, wb0;

	// stage 3: weights and differences
	logic                v_s3, fld_s3;
	logic [32:0]         w00_s3, w01_s3, w10_s3, w11_s3;
	logic [16:0]         p00_s3, p01_s3, p10_s3, p11_s3;
	logic signed [35:0]  fz0_s3, fz1_s3, fr0_s3, fr1_s3;

	// stage 4: weighted terms
	logic                v_s4, fld_s4;
	logic [49:0]         t00_s4, t01_s4, t10_s4, t11_s4;
	logic signed [35:0]  sz_s4, sr_s4;
	logic [51:0]         psum;
	logic [35:0]         mz, mr;

	// stage 5: reduced sums
	logic                v_s5, fld_s5;
	logic [27:0]         pot_s5, fz_s5, fr_s5;
	logic                zpos_s5, rpos_s5;

	// stage 6: gain products
	logic                v_s6, fld_s6;
	logic [59:0]         pp_s6, zp_s6, rp_s6;
	logic                zpos_s6, rpos_s6;
	logic [35:0]         pq;

	assign adv = !res_valid_q || result.ready;
	assign pop = adv && head_valid;

	assign ax_bits = head.axial;
	assign ax_mag  = ax_bits[31] ? (~ax_bits + 32'd1) : ax_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= head.mode;
			row_s1  <= head.row;
			col_s1  <= head.col;
			val_s1  <= head.value;
			neg_s1  <= ax_bits[31];
			max_s1  <= 64'(ax_mag) * 64'(cfg.inv_spacing);
			mrad_s1 <= 64'(head.radius) * 64'(cfg.inv_spacing);
		end
	end

	always_comb begin
		neg_eff = neg_s1 && (max_s1 != 64'd0);
		qm      = max_s1 - 64'd1;
		base_i  = neg_eff ? qm[63:40] : max_s1[63:40];
		ri0     = neg_eff ? ({1'b0, base_i} + 25'd1) : {1'b0, base_i};
		ri1     = neg_eff ? {1'b0, base_i} : ({1'b0, base_i} + 25'd1);
		fa      = neg_eff ? ~qm[39:24] : max_s1[39:24];
		cj0     = {1'b0, mrad_s1[63:40]};
		cj1     = cj0 + 25'd1;
		fb      = mrad_s1[39:24];
		rmax    = (cfg.rows_used > 8'(gpi_pkg::MAX_ROWS)) ? 8'(gpi_pkg::MAX_ROWS)
		                                                  : cfg.rows_used;
		cmax    = (cfg.cols_used > 8'(gpi_pkg::MAX_COLS)) ? 8'(gpi_pkg::MAX_COLS)
		                                                  : cfg.cols_used;
		waddr   = {row_s1[RW-1:1], col_s1[CW-1:1]};
		for (int b = 0; b < NB; b++) begin
			raddr[b] = {(ri0[0] == b[1]) ? ri0[RW-1:1] : ri1[RW-1:1],
			            (cj0[0] == b[0]) ? cj0[CW-1:1] : cj1[CW-1:1]};
			we[b]    = v_s1 && (mode_s1 == gpi_pkg::MODE_WRITE) &&
			           (row_s1[0] == b[1]) && (col_s1[0] == b[0]);
		end
	end

	for (genvar g = 0; g < NB; g++) begin : g_bank
		logic [16:0] mem [gpi_pkg::BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (adv) begin
				if (we[g]) begin
					mem[waddr] <= val_s1;
				end
				rd_s2[g] <= mem[raddr[g]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && (mode_s1 != gpi_pkg::MODE_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fld_s2  <= (mode_s1 == gpi_pkg::MODE_FIELD);
			r0p_s2  <= ri0[0];
			c0p_s2  <= cj0[0];
			okr0_s2 <= ri0 < {17'd0, rmax};
			okr1_s2 <= ri1 < {17'd0, rmax};
			okc0_s2 <= cj0 < {17'd0, cmax};
			okc1_s2 <= cj1 < {17'd0, cmax};
			a_s2    <= fa;
			b_s2    <= fb;
		end
	end

	always_comb begin
		p00 = (okr0_s2 && okc0_s2) ? rd_s2[{r0p_s2, c0p_s2}]   : 17'd0;
		p01 = (okr0_s2 && okc1_s2) ? rd_s2[{r0p_s2, ~c0p_s2}]  : 17'd0;
		p10 = (okr1_s2 && okc0_s2) ? rd_s2[{~r0p_s2, c0p_s2}]  : 17'd0;
		p11 = (okr1_s2 && okc1_s2) ? rd_s2[{~r0p_s2, ~c0p_s2}] : 17'd0;
		wa0 = 17'h10000 - {1'b0, a_s2};
		wb0 = 17'h10000 - {1'b0, b_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fld_s3 <= fld_s2;
			w00_s3 <= 33'(wb0) * 33'(wa0);
			w10_s3 <= 33'(wb0) * 33'({1'b0, a_s2});
			w01_s3 <= 33'({1'b0, b_s2}) * 33'(wa0);
			w11_s3 <= 33'({1'b0, b_s2}) * 33'({1'b0, a_s2});
			p00_s3 <= p00;
			p01_s3 <= p01;
			p10_s3 <= p10;
			p11_s3 <= p11;
			fz0_s3 <= 36'($signed({1'b0, wb0})) *
			          36'($signed({1'b0, p10}) - $signed({1'b0, p00}));
			fz1_s3 <= 36'($signed({2'b0, b_s2})) *
			          36'($signed({1'b0, p11}) - $signed({1'b0, p01}));
			fr0_s3 <= 36'($signed({1'b0, wa0})) *
			          36'($signed({1'b0, p01}) - $signed({1'b0, p00}));
			fr1_s3 <= 36'($signed({2'b0, a_s2})) *
			          36'($signed({1'b0, p11}) - $signed({1'b0, p10}));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fld_s4 <= fld_s3;
			t00_s4 <= 50'(w00_s3) * 50'(p00_s3);
			t01_s4 <= 50'(w01_s3) * 50'(p01_s3);
			t10_s4 <= 50'(w10_s3) * 50'(p10_s3);
			t11_s4 <= 50'(w11_s3) * 50'(p11_s3);
			sz_s4  <= fz0_s3 + fz1_s3;
			sr_s4  <= fr0_s3 + fr1_s3;
		end
	end

	always_comb begin
		psum = 52'(t00_s4) + 52'(t01_s4) + 52'(t10_s4) + 52'(t11_s4);
		mz   = sz_s4[35] ? (36'd0 - 36'(sz_s4)) : 36'(sz_s4);
		mr   = sr_s4[35] ? (36'd0 - 36'(sr_s4)) : 36'(sr_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fld_s5  <= fld_s4;
			pot_s5  <= psum[51:24];
			fz_s5   <= mz[35:8];
			fr_s5   <= mr[35:8];
			zpos_s5 <= !sz_s4[35] && (sz_s4 != 36'sd0);
			rpos_s5 <= !sr_s4[35] && (sr_s4 != 36'sd0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fld_s6  <= fld_s5;
			pp_s6   <= 60'(pot_s5) * 60'(cfg.potential_gain);
			zp_s6   <= 60'(fz_s5) * 60'(cfg.field_gain);
			rp_s6   <= 60'(fr_s5) * 60'(cfg.field_gain);
			zpos_s6 <= zpos_s5;
			rpos_s6 <= rpos_s5;
		end
	end

	assign pq = pp_s6[59:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.potential    <= (pq > 36'h07FFFFFFF) ? 32'h7FFFFFFF : pq[31:0];
			result.field_radial <= fld_s6 ? neg_sat(rp_s6[59:24], rpos_s6) : 32'd0;
			result.field_axial  <= fld_s6 ? neg_sat(zp_s6[59:24], zpos_s6) : 32'd0;
		end
	end

	assign result.valid = res_valid_q;

endmodule

/* rtl/core/grid_potential_interpolator.sv */
// ----------------------------------------------------------------------------
// grid_potential_interpolator: top level
// Bilinear potential and field lookup on a (z, rho) lattice.
// ----------------------------------------------------------------------------
// Sustains one item per cycle while results are taken: the table is split
// into four banks by row and column parity, so the four cell vertices are
// read in the same cycle, one per bank port. A query passes through the
// queue, pipeline stages 1 to 6 and the output register before its result
// shows; a write or a mode-3 item gives no result. Table entries hold no
// defined value until written. A four-entry queue parts intake from the
// pipeline.
module grid_potential_interpolator (
	input  logic                        clk,
	input  logic                        arst_n,
	gpi_item_if.sink                    item,
	gpi_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	gpi_pkg::cfg_t  cfg;
	logic           head_valid;
	gpi_pkg::item_t head;
	logic           pop;

	gpi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	gpi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: grid potential interpolator testbench
// Loads a corner of the potential table, then runs directed and random writes
// and queries through several register settings and three handshake patterns.
// Every result is compared field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
	import gpi_pkg::*;

	typedef struct packed {
		logic [31:0] potential;
		logic [31:0] field_radial;
		logic [31:0] field_axial;
	} lookup_t;

	localparam int LOAD_ROWS = 16;
	localparam int LOAD_COLS = 16;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gpi_item_if   item_ch();
	gpi_result_if res_ch();

	grid_potential_interpolator DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [16:0] grid [0:MAX_ROWS*MAX_COLS-1];
	logic [31:0] inv_spacing, potential_gain, field_gain;
	logic [7:0]  rows_used, cols_used;
	lookup_t     lookups_due[$];
	int          errors = 0;
	int          queries_sent = 0;
	int          writes_sent = 0;
	int          results_seen = 0;
	int          settings_run = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	longint      cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("%0t timeout", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	// sink side: random back-pressure, compare each transaction
	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		lookup_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.potential, res_ch.field_radial, res_ch.field_axial};
			results_seen++;
			if (lookups_due.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = lookups_due.pop_front();
				if (got.potential !== want.potential) begin
					$display("%0t potential exp %h act %h", $time, want.potential,
						got.potential);
					errors++;
				end
				if (got.field_radial !== want.field_radial) begin
					$display("%0t field_radial exp %h act %h", $time,
						want.field_radial, got.field_radial);
					errors++;
				end
				if (got.field_axial !== want.field_axial) begin
					$display("%0t field_axial exp %h act %h", $time,
						want.field_axial, got.field_axial);
					errors++;
				end
			end
		end
	end

	function automatic void split_pos(input logic [32:0] mag, input bit neg,
			output longint idx, output logic [15:0] frac);
		logic [63:0] m, p;
		m = {31'b0, mag} * {32'b0, inv_spacing};
		p = neg ? -m : m;
		if (p[63])
			idx = -longint'((~p) >> 40) - 1;
		else
			idx = longint'(p >> 40);
		frac = p[39:24];
	endfunction

	function automatic longint grid_at(input longint i, input longint j);
		longint rmax, cmax;
		rmax = (rows_used < MAX_ROWS) ? rows_used : MAX_ROWS;
		cmax = (cols_used < MAX_COLS) ? cols_used : MAX_COLS;
		if (i < 0) i = -i;
		if (j < 0) j = -j;
		if (i >= rmax || j >= cmax)
			return 0;
		return longint'(grid[14'(i * MAX_COLS + j)]);
	endfunction

	function automatic logic [31:0] neg_field(input longint s, input logic [31:0] g);
		logic [63:0] mag, q;
		mag = (s < 0) ? -s : s;
		q = ((mag >> 8) * {32'b0, g}) >> 24;
		if (s > 0) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			q = -q;
			return q[31:0];
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// table update or expected lookup for one accepted transaction
	task automatic predict_lookup(input item_t it);
		longint i, j, p00, p01, p10, p11, sz, sr;
		logic [15:0] a, b;
		logic [63:0] wa0, wa1, wb0, wb1, sum, pot;
		logic [31:0] ax;
		lookup_t r;
		if (it.mode == MODE_WRITE) begin
			grid[{it.row, it.col}] = it.value;
			writes_sent++;
			return;
		end
		if (it.mode == MODE_NONE)
			return;
		ax = it.axial;
		split_pos(ax[31] ? (33'h1_0000_0000 - ax) : {1'b0, ax}, ax[31], i, a);
		split_pos({2'b0, it.radius}, 1'b0, j, b);
		wa1 = 64'(a); wa0 = 64'd65536 - 64'(a);
		wb1 = 64'(b); wb0 = 64'd65536 - 64'(b);
		p00 = grid_at(i, j);
		p10 = grid_at(i + 1, j);
		p01 = grid_at(i, j + 1);
		p11 = grid_at(i + 1, j + 1);
		sum = wb0 * wa0 * p00 + wb0 * wa1 * p10 + wb1 * wa0 * p01 + wb1 * wa1 * p11;
		pot = ((sum >> 24) * {32'b0, potential_gain}) >> 24;
		if (pot > 64'h7FFF_FFFF) pot = 64'h7FFF_FFFF;
		r.potential = pot[31:0];
		if (it.mode == MODE_POT) begin
			r.field_radial = '0;
			r.field_axial = '0;
		end else begin
			sz = longint'(wb0) * (p10 - p00) + longint'(wb1) * (p11 - p01);
			sr = longint'(wa0) * (p01 - p00) + longint'(wa1) * (p11 - p10);
			r.field_radial = neg_field(sr, field_gain);
			r.field_axial = neg_field(sz, field_gain);
		end
		queries_sent++;
		lookups_due.push_back(r);
	endtask

	// called and returns at a falling edge
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid  = 1'b1;
		item_ch.mode   = it.mode;
		item_ch.row    = it.row;
		item_ch.col    = it.col;
		item_ch.value  = it.value;
		item_ch.radius = it.radius;
		item_ch.axial  = it.axial;
		do @(posedge clk); while (!item_ch.ready);
		predict_lookup(it);
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = PADDR_W'(idx) << 2; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_INV_SPACING:    inv_spacing = data;
			REG_POTENTIAL_GAIN: potential_gain = data;
			REG_FIELD_GAIN:     field_gain = data;
			REG_ROWS_USED:      rows_used = data[7:0];
			REG_COLS_USED:      cols_used = data[7:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		while (lookups_due.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] inv, pg, fg, input logic [7:0] nr, nc);
		drain();
		write_reg(REG_INV_SPACING, inv);
		write_reg(REG_POTENTIAL_GAIN, pg);
		write_reg(REG_FIELD_GAIN, fg);
		write_reg(REG_ROWS_USED, {24'b0, nr});
		write_reg(REG_COLS_USED, {24'b0, nc});
		settings_run++;
	endtask

	function automatic item_t query(input mode_t m, input logic [30:0] rad,
			input logic [31:0] ax);
		item_t it;
		it = '0;
		it.mode = m; it.radius = rad; it.axial = ax;
		it.row = 7'($urandom); it.col = 7'($urandom); it.value = 17'($urandom);
		return it;
	endfunction

	function automatic item_t entry(input logic [6:0] r, c, input logic [16:0] v);
		item_t it;
		it = '0;
		it.mode = MODE_WRITE; it.row = r; it.col = c; it.value = v;
		it.radius = 31'($urandom); it.axial = $urandom;
		return it;
	endfunction

	function automatic item_t random_item;
		int pick;
		logic [31:0] ax;
		logic [30:0] rad;
		pick = $urandom_range(99);
		if (pick < 25)
			return entry(7'($urandom), 7'($urandom), 17'($urandom));
		ax = $urandom;
		rad = 31'($urandom);
		if ($urandom_range(3) != 0) begin
			ax = $signed(ax) >>> $urandom_range(8);
			rad = rad >> $urandom_range(8);
		end
		if (pick < 30) return query(MODE_NONE, rad, ax);
		if (pick < 60) return query(MODE_POT, rad, ax);
		return query(MODE_FIELD, rad, ax);
	endfunction

	task automatic test_table_load;
		for (int r = 0; r < LOAD_ROWS; r++)
			for (int c = 0; c < LOAD_COLS; c++)
				send_item(entry(7'(r), 7'(c), 17'($urandom_range(65536))));
	endtask

	task automatic test_directed;
		send_item(entry(0, 0, 17'h1FFFF));
		send_item(entry(127, 127, 17'h10000));
		send_item(entry(126, 126, 17'h04000));
		send_item(entry(126, 127, 17'h0C000));
		send_item(entry(127, 126, 17'h0FFFF));
		send_item(entry(1, 1, 17'h0));
		send_item(entry(0, 1, 17'h08000));
		send_item(query(MODE_POT, 31'h0, 32'h0));
		send_item(query(MODE_FIELD, 31'h0, 32'h0));
		send_item(query(MODE_FIELD, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_item(query(MODE_FIELD, 31'h7FFF_FFFF, 32'h8000_0000));
		send_item(query(MODE_FIELD, 31'h0080_0000, 32'hFFFF_FFFF));
		send_item(query(MODE_FIELD, 31'h0180_0000, 32'hFF40_0000));
		send_item(query(MODE_POT, 31'h7E80_0000, 32'h7E80_0000));
		send_item(query(MODE_NONE, 31'h0100_0000, 32'h0100_0000));
		send_item(query(MODE_FIELD, 31'h0040_0000, 32'h0000_0001));
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd128, 8'd128);
		send_item(query(MODE_FIELD, 31'h0000_0100, 32'hFFFF_FF00));
		send_item(query(MODE_POT, 31'h0000_0001, 32'h0000_0001));
		apply_setting(32'h0, 32'h0, 32'h0, 8'd0, 8'd255);
		send_item(query(MODE_FIELD, 31'h0100_0000, 32'h0100_0000));
		apply_setting(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 8'd255, 8'd0);
		send_item(query(MODE_FIELD, 31'h0080_0000, 32'h0080_0000));
	endtask

	task automatic test_random(input int n);
		repeat (n) send_item(random_item());
	endtask

	task automatic test_phase(input int s_idle, input int r_idle);
		drain();
		send_idle = s_idle;
		recv_idle = r_idle;
		apply_setting(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 8'd16, 8'd16);
		test_random(65);
		apply_setting(32'h0002_0000, $urandom, $urandom, 8'd16, 8'd12);
		test_random(65);
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 8'd1);
		test_random(63);
		apply_setting($urandom_range(32'h0004_0000), $urandom, $urandom,
			8'($urandom_range(1, LOAD_ROWS)), 8'($urandom_range(1, LOAD_COLS)));
		test_random(65);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		item_ch.valid = 1'b0; item_ch.mode = '0; item_ch.row = '0; item_ch.col = '0;
		item_ch.value = '0; item_ch.radius = '0; item_ch.axial = '0;
		res_ch.ready = 1'b0;
		inv_spacing = 32'h0001_0000; potential_gain = 32'h0001_0000;
		field_gain = 32'h0001_0000; rows_used = 8'd128; cols_used = 8'd128;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_table_load();
		send_idle = 37;
		recv_idle = 76;
		test_directed();
		test_phase(37, 76);
		test_phase(76, 37);
		test_phase(0, 0);
		drain();
		$display("covered %0d queries and %0d table writes over %0d register settings,",
			queries_sent, writes_sent, settings_run);
		$display("%0d results checked under three handshake patterns", results_seen);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
